// File: rtl/core/cdfp_pkg.sv
// Shared constants, register map and field widths for the chamfer forward pass.
// No dependencies; used by the top level and by the port checker.
package cdfp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxLineDef  = 1024;
  localparam int unsigned DistBitsDef = 16;

  // Field and register widths fixed by the stream and register definitions
  localparam int unsigned DataW     = 16;  // dist_in / dist_out
  localparam int unsigned LineLenW  = 11;
  localparam int unsigned LineCntW  = 16;
  localparam int unsigned WeightW   = 10;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegLineLength = 2'd0,
    RegLineCount  = 2'd1,
    RegOrthWeight = 2'd2,
    RegDiagWeight = 2'd3
  } cdfp_reg_e;

  // Register reset values
  localparam logic [LineLenW-1:0] LineLengthRst = LineLenW'(10);
  localparam logic [LineCntW-1:0] LineCountRst  = LineCntW'(10);
  localparam logic [WeightW-1:0]  OrthWeightRst = WeightW'(256);
  localparam logic [WeightW-1:0]  DiagWeightRst = WeightW'(362);

  // Smallest frame edge; shorter settings act as this
  localparam int unsigned MinEdge = 3;

endpackage

// File: rtl/core/chamfer_distance_forward_pass.sv
// Chamfer distance transform, forward raster pass with a 3x3 mask.
// Depends on cdfp_pkg (widths, register map, reset values).
//
// Channel   | Dir | Fields (low bit first)                | Transfer when
// ----------+-----+---------------------------------------+------------------------------
// s_axis    | in  | tdata: dist_in[15:0]                  | s_axis_tvalid & s_axis_tready
// m_axis    | out | tdata: dist_out[15:0]; tuser: is_border; tlast: frame_last
//           |     |                                       | m_axis_tvalid & m_axis_tready
// cfg       | in  | cfg_idx_i selects register, cfg_wdata_i | every edge with cfg_we_i high
//
// Throughput is one pixel per clock while the output is not stalled. A pixel is
// registered in the input stage, where the four saturating sums and the minimum are
// formed, and then moves into the output register, which drives output valid and
// the result fields. The line store has one write and one read per cycle; the
// read for a pixel is issued as it is accepted, so the window over the previous
// line keeps pace with the stream.
// Reset clears counters, valid flags, the previous-pixel value and the registers;
// the line store is not cleared. A stalled output holds its data while the input
// stage takes one more pixel, then input ready drops until the output moves.
module chamfer_distance_forward_pass #(
  parameter int unsigned MAX_LINE  = cdfp_pkg::MaxLineDef,
  parameter int unsigned DIST_BITS = cdfp_pkg::DistBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cdfp_pkg::DataW-1:0]    s_axis_tdata,   // [15:0] dist_in
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cdfp_pkg::DataW-1:0]    m_axis_tdata,   // [15:0] dist_out
  output logic                          m_axis_tuser,   // [0] is_border
  output logic                          m_axis_tlast,   // frame_last
  // register write port
  input  logic                          cfg_we_i,
  input  logic [cdfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cdfp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned DistW  = DIST_BITS;
  localparam int unsigned PosW   = $clog2(MAX_LINE);
  localparam int unsigned WgtW   = cdfp_pkg::WeightW;
  localparam int unsigned SumW   = ((DistW > WgtW) ? DistW : WgtW) + 1;
  localparam int unsigned CmpW   = ((PosW + 1) > cdfp_pkg::LineLenW) ?
                                   (PosW + 1) : cdfp_pkg::LineLenW;
  localparam int unsigned CntW   = cdfp_pkg::LineCntW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [cdfp_pkg::LineLenW-1:0] line_length_q;
  logic [CntW-1:0]               line_count_q;
  logic [WgtW-1:0]               orth_weight_q;
  logic [WgtW-1:0]               diag_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= cdfp_pkg::LineLengthRst;
      line_count_q  <= cdfp_pkg::LineCountRst;
      orth_weight_q <= cdfp_pkg::OrthWeightRst;
      diag_weight_q <= cdfp_pkg::DiagWeightRst;
    end else if (cfg_we_i) begin
      unique case (cdfp_pkg::cdfp_reg_e'(cfg_idx_i))
        cdfp_pkg::RegLineLength: line_length_q <= cfg_wdata_i[cdfp_pkg::LineLenW-1:0];
        cdfp_pkg::RegLineCount:  line_count_q  <= cfg_wdata_i[CntW-1:0];
        cdfp_pkg::RegOrthWeight: orth_weight_q <= cfg_wdata_i[WgtW-1:0];
        cdfp_pkg::RegDiagWeight: diag_weight_q <= cfg_wdata_i[WgtW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp line length to [MinEdge, MAX_LINE] and line count to at least MinEdge
  logic [CmpW-1:0] len_raw, len_lim, len_m1;
  logic [CntW-1:0] cnt_lim, cnt_m1;

  always_comb begin
    len_raw = CmpW'(line_length_q);
    len_lim = (len_raw > CmpW'(MAX_LINE)) ? CmpW'(MAX_LINE) : len_raw;
    if (len_lim < CmpW'(cdfp_pkg::MinEdge)) begin
      len_lim = CmpW'(cdfp_pkg::MinEdge);
    end
    len_m1  = len_lim - CmpW'(1);
    cnt_lim = (line_count_q < CntW'(cdfp_pkg::MinEdge)) ? CntW'(cdfp_pkg::MinEdge)
                                                         : line_count_q;
    cnt_m1  = cnt_lim - CntW'(1);
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_fire;

  // input stage moves on when the output register is empty or being drained
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Position counters on the input side
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] in_pos_q;
  logic [CntW-1:0] in_line_q;
  logic            end_line, last_line, first_pos, border;

  assign end_line  = CmpW'(in_pos_q) >= len_m1;
  assign last_line = in_line_q >= cnt_m1;
  assign first_pos = (in_pos_q == '0);
  assign border    = end_line || last_line || first_pos || (in_line_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      in_line_q <= '0;
    end else if (in_fire) begin
      if (end_line) begin
        in_pos_q  <= '0;
        in_line_q <= last_line ? '0 : in_line_q + CntW'(1);
      end else begin
        in_pos_q  <= in_pos_q + PosW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store and window over the previous line
  // ---------------------------------------------------------------------------
  // Each result is written at its own position as it leaves the input stage.
  // The upper-right neighbor is read when a pixel is accepted; upper and
  // upper-left are the two previous upper-right reads, shifted along. Position
  // zero of the previous line comes from a separate head register.
  logic [DistW-1:0] line_store [MAX_LINE];
  logic [DistW-1:0] rd_data_q;
  logic [PosW-1:0]  rd_addr;
  logic [DistW-1:0] win_ul_q, win_u_q;
  logic [DistW-1:0] head_q;

  logic [DistW-1:0] s1_dist_q;
  logic [PosW-1:0]  s1_pos_q;
  logic             s1_first_q;
  logic             s1_border_q;
  logic             s1_flast_q;
  logic [DistW-1:0] prev_q;
  logic [DistW-1:0] res;

  assign rd_addr = (in_pos_q == PosW'(MAX_LINE - 1)) ? '0 : in_pos_q + PosW'(1);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_store[s1_pos_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q <= line_store[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_ul_q <= win_u_q;
      win_u_q  <= first_pos ? head_q : rd_data_q;
    end
    if (s1_adv && s1_first_q) begin
      head_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_dist_q   <= DistW'(s_axis_tdata);  // mask or extend to the distance width
      s1_pos_q    <= in_pos_q;
      s1_first_q  <= first_pos;
      s1_border_q <= border;
      s1_flast_q  <= end_line && last_line;
    end
  end

  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [WgtW-1:0]  w);
    logic [SumW-1:0] s;
    s = SumW'(a) + SumW'(w);
    return (|s[SumW-1:DistW]) ? '1 : s[DistW-1:0];
  endfunction

  function automatic logic [DistW-1:0] min2(input logic [DistW-1:0] a,
                                            input logic [DistW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [DistW-1:0] c_ul, c_ur, c_u, c_l;

  always_comb begin
    c_ul = sat_add(win_ul_q,  diag_weight_q);
    c_ur = sat_add(rd_data_q, diag_weight_q);
    c_u  = sat_add(win_u_q,   orth_weight_q);
    c_l  = sat_add(prev_q,    orth_weight_q);
    if (s1_border_q) begin
      res = s1_dist_q;  // border pixels pass through
    end else begin
      res = min2(min2(s1_dist_q, c_l), min2(min2(c_ul, c_ur), c_u));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (s1_adv) begin
      prev_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [cdfp_pkg::DataW-1:0] out_dist_q;
  logic                       out_border_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_dist_q   <= cdfp_pkg::DataW'(res);
      out_border_q <= s1_border_q;
      out_last_q   <= s1_flast_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_dist_q;
  assign m_axis_tuser  = out_border_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/cdfp_checker.sv
// Port-level checks for the chamfer forward pass, bound to the top level.
// Depends on cdfp_pkg for the field widths.
module cdfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cdfp_pkg::DataW-1:0]    m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // the final pixel of a frame is a border pixel
  a_last_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end flagged on an interior pixel");

  // a fresh result follows an input transfer via the input stage and the output register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input transfer");

  // with nothing waiting at the output, the input side must accept
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

endmodule

bind chamfer_distance_forward_pass cdfp_checker u_cdfp_checker (.*);

// File: tb/sv/tb_chamfer_distance_forward_pass.sv
// Self-checking testbench for the chamfer distance forward pass: streams frames of pixels,
// predicts every result with a local model of the transform and compares field by field.
// Depends on cdfp_pkg (widths, register indexes, reset values) and the top-level RTL.
`timescale 1ns / 1ps

module tb_chamfer_distance_forward_pass;

  localparam int unsigned MaxLine    = cdfp_pkg::MaxLineDef;
  localparam int unsigned DataW      = cdfp_pkg::DataW;
  localparam int unsigned LineLenW   = cdfp_pkg::LineLenW;
  localparam int unsigned LineCntW   = cdfp_pkg::LineCntW;
  localparam int unsigned WeightW    = cdfp_pkg::WeightW;
  localparam int unsigned CfgIdxW    = cdfp_pkg::CfgIdxW;
  localparam int unsigned CfgDataW   = cdfp_pkg::CfgDataW;
  localparam int unsigned MinEdge    = cdfp_pkg::MinEdge;
  localparam int unsigned HoldCycles = 400;        // long receiver hold-off
  localparam int unsigned CycleLimit = 2_000_000;  // watchdog
  localparam int unsigned RandItems  = 250;

  // One result of the pass, in the order the fields leave the block
  typedef struct packed {
    logic [DataW-1:0] dist_out;
    logic             border;
    logic             last;
  } pix_res_t;

  // Directed row: pixel value, whether the expected result is typed in, and that result
  typedef struct packed {
    logic [DataW-1:0] din;
    logic             typed;
    pix_res_t         want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;   // [15:0] dist_in
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;   // [15:0] dist_out
  logic                m_axis_tuser;   // [0] is_border
  logic                m_axis_tlast;   // frame_last
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  chamfer_distance_forward_pass u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Directed rows under the reset setting (10 x 10 frame, weights 256 / 362).
  // Line 0 and the line ends are border pixels and pass through; an interior zero stays
  // zero because the own value is a candidate. The rest goes through the predictor.
  localparam dir_row_t DirRows [25] = '{
    // line 0: all border
    '{16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{16'h8000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
    '{16'h0001, 1'b1, '{16'h0001, 1'b1, 1'b0}},
    '{16'hFFFE, 1'b1, '{16'hFFFE, 1'b1, 1'b0}},
    '{16'h1234, 1'b1, '{16'h1234, 1'b1, 1'b0}},
    '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0}},
    '{16'hFF00, 1'b1, '{16'hFF00, 1'b1, 1'b0}},
    '{16'hAAAA, 1'b1, '{16'hAAAA, 1'b1, 1'b0}},
    '{16'h5555, 1'b1, '{16'h5555, 1'b1, 1'b0}},
    // line 1: left border, interior, right border
    '{16'h0C00, 1'b1, '{16'h0C00, 1'b1, 1'b0}},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0100, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h4321, 1'b1, '{16'h4321, 1'b1, 1'b0}},
    // line 2: start
    '{16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'hFFFF, 1'b0, '0}
  };

  // Predictor state: previous-line store, left neighbour, raster position, registers
  logic [DataW-1:0]    row_mem [MaxLine];
  logic [DataW-1:0]    left_px;
  int unsigned         col_pos;
  int unsigned         row_idx;
  logic [LineLenW-1:0] cfg_len;
  logic [LineCntW-1:0] cfg_lines;
  logic [WeightW-1:0]  w_orth;
  logic [WeightW-1:0]  w_diag;

  pix_res_t    pending_px_q [$];  // results still owed by the block, oldest first
  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned sent_count   = 0;
  int unsigned frames_done  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned cycle_count  = 0;
  bit          calm         = 1'b0;  // phase without idling on either side

  // Free-running clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the stream hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Effective frame edges: short settings act as three, long lines are clipped
  function automatic int unsigned eff_len();
    if (cfg_len < MinEdge) return MinEdge;
    if (cfg_len > MaxLine) return MaxLine;
    return cfg_len;
  endfunction

  function automatic int unsigned eff_cnt();
    return (cfg_lines < MinEdge) ? MinEdge : cfg_lines;
  endfunction

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                               input logic [WeightW-1:0] w);
    logic [DataW:0] s;
    s = {1'b0, a} + w;
    return s[DataW] ? {DataW{1'b1}} : s[DataW-1:0];
  endfunction

  // Compute the result of one pixel and advance the predictor's raster state
  task automatic predict_pixel(input logic [DataW-1:0] din, output pix_res_t r);
    int unsigned      len;
    int unsigned      cnt;
    logic             end_line;
    logic             last_line;
    logic             border;
    logic [DataW-1:0] res;
    logic [DataW-1:0] cand [4];
    len       = eff_len();
    cnt       = eff_cnt();
    end_line  = (col_pos >= len - 1);
    last_line = (row_idx >= cnt - 1);
    border    = end_line || last_line || (col_pos == 0) || (row_idx == 0);
    res       = din;
    if (!border) begin
      cand[0] = sat_add(row_mem[col_pos-1], w_diag);
      cand[1] = sat_add(row_mem[col_pos+1], w_diag);
      cand[2] = sat_add(row_mem[col_pos], w_orth);
      cand[3] = sat_add(left_px, w_orth);
      foreach (cand[i]) if (cand[i] < res) res = cand[i];
    end
    // the entry left of this position now belongs to the current line
    if (col_pos > 0 && col_pos - 1 < MaxLine) row_mem[col_pos-1] = left_px;
    if (end_line && col_pos < MaxLine) row_mem[col_pos] = res;
    left_px    = res;
    r.dist_out = res;
    r.border   = border;
    r.last     = end_line && last_line;
    if (end_line) begin
      col_pos = 0;
      row_idx = last_line ? 0 : row_idx + 1;
    end else begin
      col_pos++;
    end
  endtask

  // Mostly short gaps, a few long ones, none in a calm phase
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Seed points, unreached pixels, noise over all bits, and small values up to 2047
  function automatic logic [DataW-1:0] next_dist();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return '0;
    if (p < 50) return '1;
    if (p < 75) return DataW'($urandom);
    return DataW'($urandom_range(0, 2047));
  endfunction

  // Offer one pixel, hold it until transfer, then queue its expected result.
  // Return at the falling edge with valid still high so back-to-back transfers stay possible.
  task automatic push_pixel(input logic [DataW-1:0] din, input logic typed,
                            input pix_res_t want);
    int unsigned gap;
    pix_res_t    r;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = din;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(din, r);
    pending_px_q.push_back(typed ? want : r);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic wait_results_done();
    s_axis_tvalid = 1'b0;
    while (pending_px_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register while the block is idle; mirror it in the predictor
  task automatic cfg_write(input cdfp_pkg::cdfp_reg_e idx,
                           input logic [CfgDataW-1:0] val);
    wait_results_done();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      cdfp_pkg::RegLineLength: cfg_len   = val[LineLenW-1:0];
      cdfp_pkg::RegLineCount:  cfg_lines = val[LineCntW-1:0];
      cdfp_pkg::RegOrthWeight: w_orth    = val[WeightW-1:0];
      cdfp_pkg::RegDiagWeight: w_diag    = val[WeightW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic logic [WeightW-1:0] pick_weight();
    int unsigned p;
    p = $urandom_range(0, 5);
    if (p == 0) return '0;
    if (p == 1) return '1;
    if (p == 2) begin
      return ($urandom_range(0, 1) != 0) ? cdfp_pkg::OrthWeightRst
                                         : cdfp_pkg::DiagWeightRst;
    end
    return WeightW'($urandom);
  endfunction

  // Feed pixels until the predictor is back at the start of a frame. Optionally pause
  // once mid-frame and change registers; the line only shrinks, so no unwritten
  // store entry is ever read.
  task automatic run_frame(input bit mid_change);
    int unsigned k;
    int unsigned cut;
    cut = mid_change ? $urandom_range(1, eff_len() * eff_cnt() - 1) : 0;
    k   = 0;
    do begin
      if (mid_change && k == cut) begin
        cfg_write(cdfp_pkg::RegLineLength, CfgDataW'($urandom_range(0, eff_len()))
                                           | (CfgDataW'($urandom) & 16'hF800));
        cfg_write(cdfp_pkg::RegLineCount, CfgDataW'($urandom_range(0, 8)));
        if ($urandom_range(0, 1) != 0) begin
          cfg_write(cdfp_pkg::RegOrthWeight, CfgDataW'(pick_weight()));
        end else begin
          cfg_write(cdfp_pkg::RegDiagWeight, CfgDataW'(pick_weight()));
        end
      end
      push_pixel(next_dist(), 1'b0, '0);
      k++;
    end while (!(col_pos == 0 && row_idx == 0));
    frames_done++;
  endtask

  // Receiver: ready in random runs with random stalls, plus one long hold-off while the
  // sender keeps offering, so the block fills and drops its input ready.
  initial begin : rx_driver
    int unsigned run;
    int unsigned gap;
    bit          held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= 300) begin
        held          = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      run = calm ? 8 : $urandom_range(1, 12);
      repeat (run) @(negedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // Compare every output transfer with the oldest owed result
  always @(posedge clk_i) begin : out_check
    pix_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_px_q.size() == 0) begin
        $error("unexpected result: dist_out %h is_border %b frame_last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_count++;
      end else begin
        want = pending_px_q.pop_front();
        if (m_axis_tdata !== want.dist_out) begin
          $error("dist_out: expected %h, got %h", want.dist_out, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser !== want.border) begin
          $error("is_border: expected %b, got %b", want.border, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %b, got %b", want.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin : stim
    int unsigned rand_start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = cdfp_pkg::RegLineLength;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    foreach (row_mem[i]) row_mem[i] = '0;
    left_px   = '0;
    col_pos   = 0;
    row_idx   = 0;
    cfg_len   = cdfp_pkg::LineLengthRst;
    cfg_lines = cdfp_pkg::LineCountRst;
    w_orth    = cdfp_pkg::OrthWeightRst;
    w_diag    = cdfp_pkg::DiagWeightRst;

    // Hold reset, then release it at a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows under the reset setting, then finish that frame
    foreach (DirRows[i]) push_pixel(DirRows[i].din, DirRows[i].typed, DirRows[i].want);
    run_frame(1'b0);

    // Smallest frames: lengths below three act as three, zero weights
    cfg_write(cdfp_pkg::RegLineLength, 16'd0);
    cfg_write(cdfp_pkg::RegLineCount, 16'd1);
    cfg_write(cdfp_pkg::RegOrthWeight, 16'd0);
    cfg_write(cdfp_pkg::RegDiagWeight, 16'd0);
    run_frame(1'b0);
    cfg_write(cdfp_pkg::RegLineLength, 16'd2);
    cfg_write(cdfp_pkg::RegLineCount, 16'd2);
    run_frame(1'b0);

    // Widest line (register top, clipped to the store depth), heaviest weights.
    // Run the first line to its clipped end and a few pixels of the next, then pause
    // until every owed result has come out and shrink the line so the frame closes.
    cfg_write(cdfp_pkg::RegLineLength, 16'h07FF);
    cfg_write(cdfp_pkg::RegLineCount, 16'd3);
    cfg_write(cdfp_pkg::RegOrthWeight, 16'h03FF);
    cfg_write(cdfp_pkg::RegDiagWeight, 16'h03FF);
    for (int unsigned k = 0; k < MaxLine + 6; k++) begin
      push_pixel(next_dist(), 1'b0, '0);
    end
    cfg_write(cdfp_pkg::RegLineLength, 16'd3);
    run_frame(1'b0);

    // Tallest frame: run some lines, then cut the line count under the current line
    // so that this line becomes the final one
    cfg_write(cdfp_pkg::RegLineLength, 16'd3);
    cfg_write(cdfp_pkg::RegLineCount, 16'hFFFF);
    cfg_write(cdfp_pkg::RegOrthWeight, CfgDataW'(cdfp_pkg::OrthWeightRst));
    cfg_write(cdfp_pkg::RegDiagWeight, CfgDataW'(cdfp_pkg::DiagWeightRst));
    repeat (60) push_pixel(next_dist(), 1'b0, '0);
    cfg_write(cdfp_pkg::RegLineCount, 16'd2);
    cfg_write(cdfp_pkg::RegOrthWeight, 16'h03FF);
    run_frame(1'b0);

    // Random phases: new setting at a frame start, one or two frames, some with a
    // mid-frame register change
    rand_start = sent_count;
    while (sent_count - rand_start < RandItems) begin
      wait_results_done();
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0, 1:    cfg_write(cdfp_pkg::RegLineLength, CfgDataW'($urandom_range(0, 2)));
          2:       cfg_write(cdfp_pkg::RegLineLength, CfgDataW'($urandom_range(25, 200)));
          default: cfg_write(cdfp_pkg::RegLineLength, CfgDataW'($urandom_range(3, 24))
                                                      | (CfgDataW'($urandom) & 16'hF800));
        endcase
      end
      if ($urandom_range(0, 3) != 0)
        cfg_write(cdfp_pkg::RegLineCount, CfgDataW'(($urandom_range(0, 9) == 0) ?
                                          $urandom_range(9, 30) : $urandom_range(0, 8)));
      if ($urandom_range(0, 3) != 0)
        cfg_write(cdfp_pkg::RegOrthWeight,
                  CfgDataW'(pick_weight()) | (CfgDataW'($urandom) & 16'hFC00));
      if ($urandom_range(0, 3) != 0)
        cfg_write(cdfp_pkg::RegDiagWeight,
                  CfgDataW'(pick_weight()) | (CfgDataW'($urandom) & 16'hFC00));
      repeat ($urandom_range(1, 2)) run_frame($urandom_range(0, 3) == 0);
    end
    calm = 1'b0;

    // Drain, let the pipeline settle, then report
    wait_results_done();
    repeat (10) @(negedge clk_i);
    if (pending_px_q.size() != 0) begin
      $error("%0d results never arrived", pending_px_q.size());
      err_count++;
    end
    $display("%0d pixels over %0d frames, %0d register writes, %0d results checked",
             sent_count, frames_done, cfg_writes, results_seen);
    $display("settings ran from 3x3 up to a clipped 1024-pixel line, weights 0 to 1023");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: chamfer_distance_forward_pass.f
rtl/core/cdfp_pkg.sv
rtl/core/chamfer_distance_forward_pass.sv
rtl/core/cdfp_checker.sv
tb/sv/tb_chamfer_distance_forward_pass.sv
